// File: design/rea_pkg.sv
// Package for the rotary encoder with acceleration: widths, codes, FSM type
// and the quadrature transition table.
// No dependencies.
`default_nettype none

package rea_pkg;

   // Internal count width: limits reach 32767 * 31, plus acceleration headroom
   localparam int CNT_W = 24;
   // Serial divider widths
   localparam int DIV_W = 24;
   localparam int DSR_W = 8;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Acceleration window and floor in milliseconds
   localparam logic [31:0] ACCEL_SLOW_MS = 32'd200;
   localparam logic [31:0] ACCEL_FAST_MS = 32'd4;

   // Configuration register indexes
   localparam logic [2:0] REG_ENABLE   = 3'd0;
   localparam logic [2:0] REG_MIN      = 3'd1;
   localparam logic [2:0] REG_MAX      = 3'd2;
   localparam logic [2:0] REG_WRAP     = 3'd3;
   localparam logic [2:0] REG_STEPS    = 3'd4;
   localparam logic [2:0] REG_COEF     = 3'd5;
   localparam logic [2:0] REG_DEBOUNCE = 3'd6;

   // Request kinds
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_SET    = 1'b1;

   // Step direction codes (also the stored last direction)
   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_UP   = 2'b01;
   localparam logic [1:0] DIR_DOWN = 2'b11;

   // Button state and event codes
   localparam logic [1:0] BTN_UNKNOWN = 2'd0;
   localparam logic [1:0] BTN_UP      = 2'd1;
   localparam logic [1:0] BTN_DOWN    = 2'd2;
   localparam logic [1:0] EVT_NONE     = 2'd0;
   localparam logic [1:0] EVT_PRESSED  = 2'd1;
   localparam logic [1:0] EVT_RELEASED = 2'd2;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_BTN   = 11'b000_0000_0010,
      S_MULN  = 11'b000_0000_0100,
      S_DIV1  = 11'b000_0000_1000,
      S_DIV2  = 11'b000_0001_0000,
      S_MULLO = 11'b000_0010_0000,
      S_MULHI = 11'b000_0100_0000,
      S_LIM   = 11'b000_1000_0000,
      S_DIVS  = 11'b001_0000_0000,
      S_DIVO  = 11'b010_0000_0000,
      S_OUT   = 11'b100_0000_0000
   } state_type;

   // Divider status back to the controller
   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
      logic [DSR_W-1:0] rem;
   } div_res_type;

   // Quadrature transition table, indexed by {old B, old A, new B, new A}
   function automatic logic [1:0] quad_dir(input logic [3:0] hist);
      logic [1:0] d;
      case (hist)
         4'd1, 4'd7, 4'd8, 4'd14: d = DIR_DOWN;
         4'd2, 4'd4, 4'd11, 4'd13: d = DIR_UP;
         default: d = DIR_NONE;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// File: design/rea_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rea_pkg.
`default_nettype none

module rea_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [rea_pkg::DIV_W-1:0] dividend,
   input  wire logic [rea_pkg::DSR_W-1:0] divisor,
   output rea_pkg::div_res_type           res
);
   import rea_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DSR_W-1:0]     rem_ff;
   logic [DSR_W-1:0]     dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DSR_W:0]       trial;
   logic                 fits;

   // Shift in next dividend bit and try the subtraction
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res.done = done_ff;
   assign res.quot = quo_ff;
   assign res.rem  = rem_ff;

endmodule

`default_nettype wire

// File: design/rotary_encoder_with_acceleration.sv
// Top level of the rotary encoder decoder with acceleration and button debounce.
// Depends on rea_pkg and rea_div.
`default_nettype none

// One request at a time. A sample request in which the encoder moves with
// acceleration makes three passes of the serial divider; without acceleration
// the acceleration divide is skipped, and a sample that does not move the
// encoder, or a set request, runs only the divide for the detent position.
// A finished result waits in the output register while the next request is
// accepted.
module rotary_encoder_with_acceleration (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata = pin_a, pin_b, button_level, now_ms[31:0], new_position[15:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic        req_tuser,  // opcode
   // result: tdata = position_detents[15:0], button_state[1:0], button_event[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import rea_pkg::*;

   // Configuration registers
   logic               enable_ff;
   logic signed [15:0] min_ff;
   logic signed [15:0] max_ff;
   logic               wrap_ff;
   logic [4:0]         steps_ff;
   logic [15:0]        coef_ff;
   logic [9:0]         deb_ff;

   // Captured request
   logic               op_ff;
   logic               a_ff;
   logic               b_ff;
   logic               lvl_ff;
   logic [31:0]        now_ff;
   logic signed [15:0] newpos_ff;

   // Block state
   logic [3:0]              hist_ff;
   logic signed [CNT_W-1:0] count_ff;
   logic [31:0]             last_ms_ff;
   logic [1:0]              last_dir_ff;
   logic                    prev_inv_ff;
   logic [31:0]             chg_ms_ff;
   logic [1:0]              rep_ff;

   // Working registers
   state_type               state_ff;
   logic [1:0]              dir_ff;
   logic signed [CNT_W-1:0] cand_ff;
   logic signed [CNT_W-1:0] lo_ff;
   logic signed [CNT_W-1:0] hi_ff;
   logic [1:0]              bstate_ff;
   logic [1:0]              event_ff;

   // Output register
   logic        rsp_valid_ff;
   logic [15:0] rsp_pos_ff;
   logic [1:0]  rsp_state_ff;
   logic [1:0]  rsp_event_ff;

   // Combinational helpers
   logic [4:0]              eff_steps;
   logic [DSR_W-1:0]        steps_dsr;
   logic [3:0]              hist_in;
   logic [1:0]              dir_in;
   logic                    moving;
   logic [DIV_W-1:0]        count_mag;
   logic [31:0]             el_btn;
   logic                    changed;
   logic [1:0]              bstate_in;
   logic [31:0]             el_acc;
   logic [DSR_W-1:0]        el_div;
   logic                    chg_detent;
   logic signed [15:0]      mul_a;
   logic signed [21:0]      mul_p;
   logic signed [CNT_W-1:0] lim_hi;
   logic signed [CNT_W-1:0] lim_out;
   logic [DIV_W-1:0]        detent_full;
   logic                    out_free;
   logic                    div_start;
   logic [DIV_W-1:0]        div_dividend;
   logic [DSR_W-1:0]        div_divisor;
   div_res_type             div_res;

   rea_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .res      (div_res)
   );

   // Steps of zero act as one
   assign eff_steps = (steps_ff == 5'd0) ? 5'd1 : steps_ff;
   assign steps_dsr = {3'b000, eff_steps};

   // Encoder decode
   assign hist_in = {hist_ff[1:0], b_ff, a_ff};
   assign dir_in  = quad_dir(hist_in);
   assign moving  = (op_ff == OP_SAMPLE) && enable_ff && (dir_in != DIR_NONE);

   assign count_mag = count_ff[CNT_W-1] ? DIV_W'(-count_ff) : DIV_W'(count_ff);

   // Button debounce: a fresh change restarts the stable time
   assign el_btn    = now_ff - chg_ms_ff;
   assign changed   = (op_ff == OP_SAMPLE) && ((~lvl_ff) != prev_inv_ff);
   assign bstate_in = (!changed && (el_btn > {22'd0, deb_ff})) ?
                      (lvl_ff ? BTN_UP : BTN_DOWN) : BTN_UNKNOWN;

   // Time since the last detent move, floored for the division
   assign el_acc = now_ff - last_ms_ff;
   assign el_div = (el_acc < ACCEL_FAST_MS) ? ACCEL_FAST_MS[DSR_W-1:0] : el_acc[DSR_W-1:0];

   // Detent crossing from the remainder of |count| / steps
   always_comb begin
      if (dir_ff == DIR_UP) begin
         chg_detent = count_ff[CNT_W-1] ? (div_res.rem == '0)
                                        : (div_res.rem == DSR_W'(steps_dsr - 1'b1));
      end else begin
         chg_detent = (count_ff > 0) ? (div_res.rem == '0)
                                     : (div_res.rem == DSR_W'(steps_dsr - 1'b1));
      end
   end

   // Shared multiplier for position and limit scaling
   always_comb begin
      case (state_ff)
         S_MULN:  mul_a = newpos_ff;
         S_MULLO: mul_a = min_ff;
         default: mul_a = max_ff;
      endcase
   end
   assign mul_p = 22'(mul_a) * 22'($signed({1'b0, eff_steps}));

   // Limit rule: upper test first, then lower
   assign lim_hi  = (cand_ff > hi_ff) ? (wrap_ff ? lo_ff : hi_ff) : cand_ff;
   assign lim_out = (lim_hi < lo_ff) ? (wrap_ff ? hi_ff : lo_ff) : lim_hi;

   assign detent_full = count_ff[CNT_W-1] ? DIV_W'(-div_res.quot) : div_res.quot;

   // Divider launch
   always_comb begin
      div_start    = 1'b0;
      div_dividend = count_mag;
      div_divisor  = steps_dsr;
      case (state_ff)
         S_BTN:  div_start = (op_ff == OP_SAMPLE);
         S_DIVS: div_start = 1'b1;
         S_DIV1: begin
            if (div_res.done && chg_detent && (coef_ff > 16'd1) &&
                (dir_ff == last_dir_ff) && (el_acc < ACCEL_SLOW_MS)) begin
               div_start    = 1'b1;
               div_dividend = {8'd0, coef_ff};
               div_divisor  = el_div;
            end
         end
         default: div_start = 1'b0;
      endcase
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         min_ff    <= 16'sd0;
         max_ff    <= 16'sd100;
         wrap_ff   <= 1'b0;
         steps_ff  <= 5'd4;
         coef_ff   <= 16'd0;
         deb_ff    <= 10'd50;
      end else if (csr_we) begin
         case (csr_index)
            REG_ENABLE:   enable_ff <= csr_wdata[0];
            REG_MIN:      min_ff    <= csr_wdata;
            REG_MAX:      max_ff    <= csr_wdata;
            REG_WRAP:     wrap_ff   <= csr_wdata[0];
            REG_STEPS:    steps_ff  <= csr_wdata[4:0];
            REG_COEF:     coef_ff   <= csr_wdata;
            REG_DEBOUNCE: deb_ff    <= csr_wdata[9:0];
            default:      enable_ff <= enable_ff;
         endcase
      end
   end

   // Request capture (payload, no reset)
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff     <= req_tuser;
         a_ff      <= req_tdata[0];
         b_ff      <= req_tdata[1];
         lvl_ff    <= req_tdata[2];
         now_ff    <= req_tdata[34:3];
         newpos_ff <= req_tdata[50:35];
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      case (state_ff)
         S_BTN: begin
            dir_ff    <= dir_in;
            bstate_ff <= bstate_in;
         end
         S_MULN:  cand_ff <= CNT_W'(mul_p);
         S_DIV1:  cand_ff <= count_ff + ((dir_ff == DIR_UP) ? CNT_W'(1) : -CNT_W'(1));
         S_DIV2: begin
            if (div_res.done) begin
               cand_ff <= (dir_ff == DIR_UP) ? cand_ff + CNT_W'(div_res.quot)
                                             : cand_ff - CNT_W'(div_res.quot);
            end
         end
         S_MULLO: lo_ff <= CNT_W'(mul_p);
         S_MULHI: hi_ff <= CNT_W'(mul_p);
         default: cand_ff <= cand_ff;
      endcase
   end

   // Controller and block state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hist_ff      <= 4'd0;
         count_ff     <= '0;
         last_ms_ff   <= 32'd0;
         last_dir_ff  <= DIR_NONE;
         prev_inv_ff  <= 1'b1;
         chg_ms_ff    <= 32'd0;
         rep_ff       <= BTN_UNKNOWN;
         event_ff     <= EVT_NONE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_BTN;
               end
            end
            // Button update, history shift and first divide for a sample; a set only clears the event
            S_BTN: begin
               if (op_ff == OP_SET) begin
                  event_ff <= EVT_NONE;
                  state_ff <= S_MULN;
               end else begin
                  if (changed) begin
                     chg_ms_ff   <= now_ff;
                     prev_inv_ff <= ~lvl_ff;
                  end
                  if (enable_ff) begin
                     hist_ff <= hist_in;
                  end
                  if ((bstate_in != BTN_UNKNOWN) && (bstate_in != rep_ff)) begin
                     if (rep_ff != BTN_UNKNOWN) begin
                        event_ff <= (bstate_in == BTN_DOWN) ? EVT_PRESSED : EVT_RELEASED;
                     end else begin
                        event_ff <= EVT_NONE;
                     end
                     rep_ff <= bstate_in;
                  end else begin
                     event_ff <= EVT_NONE;
                  end
                  state_ff <= moving ? S_DIV1 : S_DIVO;
               end
            end
            S_MULN: state_ff <= S_MULLO;
            // Detent crossing and acceleration decision
            S_DIV1: begin
               if (div_res.done) begin
                  if (chg_detent && (coef_ff > 16'd1)) begin
                     last_ms_ff  <= now_ff;
                     last_dir_ff <= dir_ff;
                  end
                  state_ff <= div_start ? S_DIV2 : S_MULLO;
               end
            end
            S_DIV2: begin
               if (div_res.done) begin
                  state_ff <= S_MULLO;
               end
            end
            S_MULLO: state_ff <= S_MULHI;
            S_MULHI: state_ff <= S_LIM;
            S_LIM: begin
               count_ff <= lim_out;
               state_ff <= S_DIVS;
            end
            S_DIVS: state_ff <= S_DIVO;
            S_DIVO: begin
               if (div_res.done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Result valid: set when a result is loaded, cleared once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload, loaded only once the output register is free
   always_ff @(posedge clock) begin
      if ((state_ff == S_OUT) && out_free) begin
         rsp_pos_ff   <= detent_full[15:0];
         rsp_state_ff <= bstate_ff;
         rsp_event_ff <= event_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_event_ff, rsp_state_ff, rsp_pos_ff};

endmodule

`default_nettype wire

// File: verif/rea_checker.sv
// Checker for the rotary encoder with acceleration: watches the request,
// result and register-write ports, predicts each result and compares.
// Depends on rea_pkg.
`default_nettype none

module rea_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rea_pkg::*;

   // packed from the top bit down: event, state, position
   typedef struct packed {
      logic [1:0]  bevent;
      logic [1:0]  bstate;
      logic [15:0] detents;
   } enc_result_type;

   // register copies
   logic        r_enable, r_wrap;
   logic [15:0] r_min, r_max, r_coef;
   logic [4:0]  r_steps;
   logic [9:0]  r_debounce;

   // decoder state
   logic [3:0]  hist;
   longint      count;
   logic [31:0] move_ms;
   int          last_dir;
   logic        btn_inv;
   logic [31:0] btn_change_ms;
   logic [1:0]  shown_btn;

   enc_result_type expected_q[$];

   assign pending_count = expected_q.size();

   function automatic longint eff_steps();
      return (r_steps == 0) ? 1 : longint'(r_steps);
   endfunction

   function automatic longint clip(longint c);
      longint lo, hi;
      lo = longint'($signed(r_min)) * eff_steps();
      hi = longint'($signed(r_max)) * eff_steps();
      if (c > hi) c = r_wrap ? lo : hi;
      if (c < lo) c = r_wrap ? hi : lo;
      return c;
   endfunction

   function automatic logic [1:0] read_button(logic lvl, logic [31:0] now);
      logic [31:0] el;
      el = now - btn_change_ms;
      if (el > 32'(r_debounce)) return lvl ? BTN_UP : BTN_DOWN;
      return BTN_UNKNOWN;
   endfunction

   // advance the predicted state by one request
   task automatic decode(logic op, logic [55:0] d);
      logic a, b, lvl;
      logic [31:0] now, el;
      logic [15:0] newpos;
      enc_result_type r;
      int dir;
      longint c, add;
      a = d[0]; b = d[1]; lvl = d[2]; now = d[34:3]; newpos = d[50:35];
      r.bevent = EVT_NONE;
      if (op == OP_SET) begin
         count = clip(longint'($signed(newpos)) * eff_steps());
         r.bstate = read_button(lvl, now);
      end else begin
         if (!lvl != btn_inv) begin
            btn_change_ms = now;
            btn_inv = !lvl;
         end
         if (r_enable) begin
            hist = {hist[1:0], b, a};
            case (hist)
               4'd1, 4'd7, 4'd8, 4'd14: dir = -1;
               4'd2, 4'd4, 4'd11, 4'd13: dir = 1;
               default: dir = 0;
            endcase
            if (dir != 0) begin
               c = count + dir;
               if (c / eff_steps() != count / eff_steps() && r_coef > 1) begin
                  if (dir == last_dir) begin
                     el = now - move_ms;
                     if (el < 200) begin
                        if (el < 4) el = 4;
                        add = longint'(r_coef) / longint'(el);
                        c += (dir > 0) ? add : -add;
                     end
                  end
                  move_ms = now;
                  last_dir = dir;
               end
               count = clip(c);
            end
         end
         r.bstate = read_button(lvl, now);
         if (r.bstate != BTN_UNKNOWN && r.bstate != shown_btn) begin
            if (shown_btn != BTN_UNKNOWN)
               r.bevent = (r.bstate == BTN_DOWN) ? EVT_PRESSED : EVT_RELEASED;
            shown_btn = r.bstate;
         end
      end
      r.detents = 16'(count / eff_steps());
      expected_q.push_back(r);
   endtask

   always @(posedge clock) begin
      enc_result_type got, want;
      if (reset) begin
         r_enable = 1; r_min = 0; r_max = 100; r_wrap = 0; r_steps = 4;
         r_coef = 0; r_debounce = 50;
         hist = 0; count = 0; move_ms = 0; last_dir = 0; btn_inv = 1;
         btn_change_ms = 0; shown_btn = BTN_UNKNOWN;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ENABLE:   r_enable = csr_wdata[0];
               REG_MIN:      r_min = csr_wdata;
               REG_MAX:      r_max = csr_wdata;
               REG_WRAP:     r_wrap = csr_wdata[0];
               REG_STEPS:    r_steps = csr_wdata[4:0];
               REG_COEF:     r_coef = csr_wdata;
               REG_DEBOUNCE: r_debounce = csr_wdata[9:0];
               default: ;
            endcase
         end
         // result side is checked before the new request's prediction lands
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[19:0];
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.detents !== want.detents) begin
                  $display("%0t: position expected %0d actual %0d", $time,
                     $signed(want.detents), $signed(got.detents));
                  fail_count++;
               end
               if (got.bstate !== want.bstate) begin
                  $display("%0t: button state expected %0d actual %0d", $time,
                     want.bstate, got.bstate);
                  fail_count++;
               end
               if (got.bevent !== want.bevent) begin
                  $display("%0t: button event expected %0d actual %0d", $time,
                     want.bevent, got.bevent);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) decode(req_tuser, req_tdata);
      end
   end
endmodule

`default_nettype wire

// File: verif/rotary_encoder_with_acceleration_tb.sv
// Testbench top for the rotary encoder with acceleration: clock, reset,
// register phases, directed and random requests, verdict.
// Depends on rea_pkg, rea_checker and the block.
`default_nettype none

module rotary_encoder_with_acceleration_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rea_pkg::*;

   localparam int WATCHDOG = 20000;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [55:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;
   int          fail_count, pending_count;
   int          idle_cycles;
   bit          no_gaps;
   logic [31:0] clock_ms;
   logic [1:0]  quad_pos;
   logic        btn_lvl;

   rotary_encoder_with_acceleration i_dut (.*);

   rea_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver stalls
   always @(negedge clock)
      rsp_tready <= no_gaps || ($urandom_range(99) >= 26);

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // driven at the falling edge, so a request may follow straight on
   task automatic send(logic op, logic a, logic b, logic lvl, logic [31:0] now,
                       logic [15:0] pos);
      while (!no_gaps && $urandom_range(99) < 26) @(negedge clock);
      req_tvalid = 1;
      req_tuser = op;
      req_tdata = {5'b0, pos, now, lvl, b, a};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      csr_we = 1; csr_index = idx; csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
   endtask

   // let outstanding results drain before a register phase
   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   // one encoder step in quadrature order, with time moving on
   task automatic turn(int dir, int dt);
      logic [1:0] g;
      quad_pos = quad_pos + 2'(dir);
      g = {quad_pos[1], quad_pos[1] ^ quad_pos[0]};
      clock_ms += 32'(dt);
      send(OP_SAMPLE, g[0], g[1], btn_lvl, clock_ms, 16'($urandom));
   endtask

   task automatic random_phase(int n);
      int k, dir;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0: send(OP_SET, 1'($urandom), 1'($urandom), 1'($urandom), clock_ms,
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(120)));
            1: send(OP_SAMPLE, 1'($urandom), 1'($urandom), 1'($urandom), $urandom,
                    16'($urandom));
            2: begin
               btn_lvl = 1'($urandom);
               clock_ms += $urandom_range(80);
               send(OP_SAMPLE, quad_pos[1] ^ quad_pos[0], quad_pos[1], btn_lvl,
                    clock_ms, 16'($urandom));
            end
            default: begin
               dir = ($urandom_range(5) == 0) ? -1 : 1;
               if ($urandom_range(1)) dir = -dir;
               turn(dir, $urandom_range(3) == 0 ? $urandom_range(300) : $urandom_range(8));
            end
         endcase
      end
   endtask

   initial begin
      int k;
      reset = 1; req_tvalid = 0; req_tuser = 0; req_tdata = 0;
      csr_we = 0; csr_index = 0; csr_wdata = 0; rsp_tready = 0;
      no_gaps = 0; clock_ms = 0; quad_pos = 0; btn_lvl = 1; idle_cycles = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: field extremes, both ops, button edges, time wrap
      send(OP_SAMPLE, 0, 0, 1, 32'hFFFF_FFFF, 16'h0000);
      send(OP_SAMPLE, 1, 1, 0, 32'h0000_0000, 16'hFFFF);
      send(OP_SET, 1, 1, 1, 32'd100, 16'h7FFF);
      send(OP_SET, 0, 0, 0, 32'd200, 16'h8000);
      send(OP_SET, 0, 0, 1, 32'd300, 16'd50);
      btn_lvl = 1;
      for (k = 0; k < 8; k++) turn(1, 2);
      for (k = 0; k < 6; k++) turn(-1, 60);
      btn_lvl = 0; turn(0, 1); turn(0, 100);
      btn_lvl = 1; turn(0, 100);
      drain();

      // acceleration on, wrap, crossed and extreme limits, encoder disabled
      csr_write(REG_COEF, 16'hFFFF);
      csr_write(REG_WRAP, 1);
      csr_write(REG_STEPS, 0);
      csr_write(REG_DEBOUNCE, 0);
      no_gaps = 1;
      random_phase(150);
      no_gaps = 0;
      drain();
      csr_write(REG_MIN, 16'h8000);
      csr_write(REG_MAX, 16'h7FFF);
      csr_write(REG_STEPS, 31);
      csr_write(REG_COEF, 1);
      csr_write(REG_DEBOUNCE, 1000);
      random_phase(150);
      drain();
      csr_write(REG_MIN, 16'd20);
      csr_write(REG_MAX, 16'hFFF6);
      csr_write(REG_WRAP, 0);
      csr_write(REG_STEPS, 1);
      csr_write(REG_COEF, 16'd900);
      csr_write(REG_DEBOUNCE, 10);
      random_phase(150);
      drain();
      csr_write(REG_ENABLE, 0);
      random_phase(50);
      drain();
      csr_write(REG_ENABLE, 1);
      csr_write(REG_MIN, 16'hFFC0);
      csr_write(REG_MAX, 16'd40);
      csr_write(REG_STEPS, 16);
      csr_write(REG_COEF, 16'd3000);
      csr_write(REG_WRAP, 1);
      random_phase(230);

      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

`default_nettype wire

// File: sim.f
design/rea_pkg.sv
design/rea_div.sv
design/rotary_encoder_with_acceleration.sv
verif/rea_checker.sv
verif/rotary_encoder_with_acceleration_tb.sv
